// ===== rtl/fbpa_pkg.sv =====
`timescale 1ns / 1ps

package fbpa_pkg;

  // Fixed field widths of the request and response transfers
  localparam int OFFSET_W    = 16;
  localparam int STATUS_W    = 2;
  localparam int ALLOC_OFF_W = 12;
  localparam int IN_USE_W    = 7;

  // Used map is stored as words of WORD_BITS block bits
  localparam int WORD_BITS = 8;
  localparam int BIT_W     = 3;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_RANGE    = 2'd2,
    ST_NOT_USED = 2'd3
  } status_t;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_FREE_CHK,
    S_ALLOC_CHK,
    S_DONE
  } state_t;

endpackage

// ===== rtl/fbpa_if.sv =====
`timescale 1ns / 1ps

interface fbpa_req_if import fbpa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                req_type;
  logic [OFFSET_W-1:0] byte_offset;

  modport source (output valid, output req_type, output byte_offset, input ready);
  modport sink   (input valid, input req_type, input byte_offset, output ready);
endinterface

interface fbpa_rsp_if import fbpa_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [STATUS_W-1:0]    status;
  logic [ALLOC_OFF_W-1:0] alloc_offset;
  logic [IN_USE_W-1:0]    blocks_in_use;

  modport source (output valid, output status, output alloc_offset, output blocks_in_use,
                  input ready);
  modport sink   (input valid, input status, input alloc_offset, input blocks_in_use,
                  output ready);
endinterface

// ===== rtl/fbpa_ram.sv =====
`timescale 1ns / 1ps

module fbpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/fbpa_div.sv =====
`timescale 1ns / 1ps

// Division by a fixed divisor through a reciprocal multiply, quotient
// registered on start, as done is. RECIP = ceil(2^SHIFT / DIVISOR) with
// SHIFT = OFFSET_W + clog2(DIVISOR) is exact for every OFFSET_W-bit dividend.
module fbpa_div import fbpa_pkg::*; #(
  parameter int DIVISOR = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [OFFSET_W-1:0] dividend,
  output logic                done,
  output logic [OFFSET_W-1:0] quotient
);

  localparam int              SHIFT   = OFFSET_W + $clog2(DIVISOR);
  localparam int              RECIP_W = OFFSET_W + 1;
  localparam int              PROD_W  = OFFSET_W + RECIP_W;
  localparam longint unsigned RECIP   =
    ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);

  logic [PROD_W-1:0] prod;

  // 16 x 17 bit product
  assign prod = {{RECIP_W{1'b0}}, dividend} * {{OFFSET_W{1'b0}}, RECIP_C};

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= OFFSET_W'(prod >> SHIFT);
    end
  end

endmodule

// ===== rtl/fixed_block_pool_allocator.sv =====
`timescale 1ns / 1ps

// Fixed-size block pool allocator, first fit over a used/free bitmap.
// One request at a time. An allocate request walks the map one 8-block word
// per cycle from block 0 and claims the lowest free block, stopping at the
// first word with a free block or at the last word for a full pool; each
// word is read through the map RAM read port. A free request first divides
// the byte offset by BLOCK_BYTES with a registered reciprocal multiply, then
// does one read-modify-write of the map word, skipped when the offset is
// past the pool. A finished response sits in an output register, so the
// next request can be taken while the response waits for the sink.
// The map words carry one valid flop each, cleared at reset, so a pool
// is usable on the cycle after reset with no clearing pass.
// Status: ok, pool full, free offset out of range, free of an unused block.
// blocks_in_use is the used count after the request, taken modulo 128.
module fixed_block_pool_allocator import fbpa_pkg::*; #(
  parameter int NUM_BLOCKS  = 64,
  parameter int BLOCK_BYTES = 64
) (
  input logic       clk,
  input logic       rst,
  fbpa_req_if.sink   req,
  fbpa_rsp_if.source rsp
);

  localparam int ROWS      = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CNT_W     = $clog2(NUM_BLOCKS + 1);
  localparam int TAIL_BITS = NUM_BLOCKS - (ROWS - 1) * WORD_BITS;
  // blocks that exist in the last map word
  localparam logic [WORD_BITS-1:0] TAIL_MASK = WORD_BITS'((2 ** TAIL_BITS) - 1);
  localparam logic [ROW_W-1:0]     LAST_ROW  = ROW_W'(ROWS - 1);

  state_t state, state_next;

  logic [ROW_W-1:0]     cur_row;
  logic [BIT_W-1:0]     cur_bit;
  logic [ROW_W-1:0]     rd_row;
  logic [ROW_W-1:0]     raddr;
  logic [ROWS-1:0]      row_valid;
  logic [WORD_BITS-1:0] rdata;
  logic [WORD_BITS-1:0] word;
  logic [WORD_BITS-1:0] avail;
  logic [WORD_BITS-1:0] new_word;
  logic                 we;
  logic [CNT_W-1:0]     used_count;
  status_t              st;
  logic                 is_free;

  logic                div_start;
  logic                div_done;
  logic [OFFSET_W-1:0] quotient;
  logic                in_range;
  logic [ROW_W-1:0]    q_row;
  logic [BIT_W-1:0]    q_bit;

  logic             found;
  logic [BIT_W-1:0] found_bit;
  logic             last_row;
  logic             accept;
  logic             rsp_load;
  logic [31:0]      offset_prod;

  logic                   rsp_valid;
  status_t                rsp_status;
  logic [ALLOC_OFF_W-1:0] rsp_alloc;
  logic [IN_USE_W-1:0]    rsp_in_use;

  assign req.ready         = (state == S_IDLE);
  assign accept            = req.valid && req.ready;
  assign rsp.valid         = rsp_valid;
  assign rsp.status        = rsp_status;
  assign rsp.alloc_offset  = rsp_alloc;
  assign rsp.blocks_in_use = rsp_in_use;

  // ---------------------------------------------------------------------
  // Offset to block index
  // ---------------------------------------------------------------------
  fbpa_div #(.DIVISOR(BLOCK_BYTES)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (req.byte_offset),
    .done     (div_done),
    .quotient (quotient)
  );

  assign in_range = quotient < OFFSET_W'(NUM_BLOCKS);
  assign q_row    = quotient[ROW_W+BIT_W-1:BIT_W];
  assign q_bit    = quotient[BIT_W-1:0];

  // ---------------------------------------------------------------------
  // Used map: one word per row, read data gated by the row valid flop
  // ---------------------------------------------------------------------
  fbpa_ram #(.WIDTH(WORD_BITS), .DEPTH(ROWS)) u_map (
    .clk   (clk),
    .we    (we),
    .waddr (cur_row),
    .wdata (new_word),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign word     = row_valid[rd_row] ? rdata : '0;
  assign last_row = (cur_row == LAST_ROW);
  // bits past the pool in the last word never count as free
  assign avail    = ~word & (last_row ? TAIL_MASK : '1);

  // lowest free bit of the word
  always_comb begin
    found     = 1'b0;
    found_bit = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (avail[b]) begin
        found     = 1'b1;
        found_bit = BIT_W'(b);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (req.req_type == REQ_FREE) ? S_DIV : S_ALLOC_CHK;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_next = in_range ? S_FREE_CHK : S_DONE;
        end
      end
      S_FREE_CHK: state_next = S_DONE;
      S_ALLOC_CHK: begin
        if (found || last_row) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (rsp_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    raddr     = cur_row;
    we        = 1'b0;
    new_word  = word;
    rsp_load  = 1'b0;
    unique case (state)
      S_IDLE: begin
        div_start = accept && (req.req_type == REQ_FREE);
        raddr     = '0;                 // first word of an allocate scan
      end
      S_DIV: raddr = q_row;
      S_FREE_CHK: begin
        we       = word[cur_bit];
        new_word = word & ~(WORD_BITS'(1) << cur_bit);
      end
      S_ALLOC_CHK: begin
        // prefetch the next word while this one is checked
        raddr    = last_row ? cur_row : cur_row + 1'b1;
        we       = found;
        new_word = word | (WORD_BITS'(1) << found_bit);
      end
      S_DONE: rsp_load = !rsp_valid || rsp.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      row_valid  <= '0;
      used_count <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (we) begin
        row_valid[cur_row] <= 1'b1;
      end
      if (state == S_ALLOC_CHK && found) begin
        used_count <= used_count + 1'b1;
      end else if (state == S_FREE_CHK && we && used_count != '0) begin
        used_count <= used_count - 1'b1;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  assign offset_prod = 32'({cur_row, cur_bit}) * 32'(BLOCK_BYTES);

  always_ff @(posedge clk) begin
    rd_row <= raddr;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cur_row <= '0;
          is_free <= req.req_type;
        end
      end
      S_DIV: begin
        if (div_done) begin
          cur_row <= q_row;
          cur_bit <= q_bit;
          st      <= in_range ? ST_OK : ST_RANGE;
        end
      end
      S_FREE_CHK: st <= word[cur_bit] ? ST_OK : ST_NOT_USED;
      S_ALLOC_CHK: begin
        if (found) begin
          cur_bit <= found_bit;
          st      <= ST_OK;
        end else if (last_row) begin
          st <= ST_FULL;
        end else begin
          cur_row <= cur_row + 1'b1;
        end
      end
      S_DONE: begin
        if (rsp_load) begin
          rsp_status <= st;
          rsp_alloc  <= (!is_free && st == ST_OK) ? offset_prod[ALLOC_OFF_W-1:0] : '0;
          rsp_in_use <= IN_USE_W'(used_count);
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/fbpa_checker.sv =====
`timescale 1ns / 1ps

module fbpa_checker import fbpa_pkg::*; #(
  parameter int NUM_BLOCKS = 64
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   req_valid,
  input logic                   req_ready,
  input logic                   rsp_valid,
  input logic                   rsp_ready,
  input logic [STATUS_W-1:0]    rsp_status,
  input logic [ALLOC_OFF_W-1:0] rsp_alloc,
  input logic [IN_USE_W-1:0]    rsp_in_use
);

  // response holds until taken
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_alloc)
      && $stable(rsp_in_use))
    else $error("response changed while stalled");

  // one request in flight: ready drops after every accepted transfer
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while busy");

  // out of reset the block is idle with nothing to deliver
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> req_ready && !rsp_valid)
    else $error("not idle after reset");

  // a full pool means every block is counted as used
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == ST_FULL |-> rsp_in_use == IN_USE_W'(NUM_BLOCKS))
    else $error("pool full with free blocks left");

  // only a successful allocate reports an offset
  a_offset_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == ST_FULL || rsp_status == ST_RANGE
      || rsp_status == ST_NOT_USED) |-> rsp_alloc == '0)
    else $error("offset reported on a failed request");

endmodule

bind fixed_block_pool_allocator fbpa_checker #(.NUM_BLOCKS(NUM_BLOCKS)) u_fbpa_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_status (rsp.status),
  .rsp_alloc  (rsp.alloc_offset),
  .rsp_in_use (rsp.blocks_in_use)
);
